>>> hw/rtl/cit_pkg.sv
package cit_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [3:0]  reg_addr;
        logic [7:0]  write_data;
        logic [15:0] tick_cycles;
    } t_item;

    // register map
    localparam logic [3:0] REG_TA_LO = 4'd4;
    localparam logic [3:0] REG_TA_HI = 4'd5;
    localparam logic [3:0] REG_TB_LO = 4'd6;
    localparam logic [3:0] REG_TB_HI = 4'd7;
    localparam logic [3:0] REG_ICR   = 4'd13;
    localparam logic [3:0] REG_CRA   = 4'd14;
    localparam logic [3:0] REG_CRB   = 4'd15;

    // configuration register indexes
    localparam logic CFG_UNIT_IS_SECOND = 1'b0;
    localparam logic CFG_IRQ_ENABLE     = 1'b1;

    // timer B count sources
    localparam logic [1:0] SRC_CYCLES = 2'd0;
    localparam logic [1:0] SRC_CHAIN  = 2'd2;

endpackage

>>> hw/rtl/complex_interface_timer_pair_unit.sv
// Pipeline: an input transfer loads the input register, and the item moves on into the result
// register once that is free or being taken (input register, result register).
// Throughput: one item per cycle while the result side does not stall; the timer state update is
// a single compare/subtract pass between the input register and the result register.
// Reset: synchronous, active low; clears all timer state, flags and register bytes,
// sets irq_enable to 1 and unit_is_second to 0. No clearing pass.
module complex_interface_timer_pair_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_tick_cycles,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_irq_request,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);

    logic            r_in_valid;
    cit_pkg::t_item  r_in_item;
    logic            r_out_valid;
    logic [7:0]      r_read_data;
    logic            r_irq_request;
    cit_pkg::t_func  r_out_func;
    logic            w_advance;
    logic [7:0]      w_read_data;
    logic            w_irq_request;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in_item <= '{func: cit_pkg::t_func'(i_func), reg_addr: i_reg_addr,
                           write_data: i_write_data, tick_cycles: i_tick_cycles};
        end
        if (w_advance) begin
            r_read_data   <= w_read_data;
            r_irq_request <= w_irq_request;
            r_out_func    <= r_in_item.func;
        end
    end

    cit_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_advance),
        .i_item        (r_in_item),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_read_data   (w_read_data),
        .o_irq_request (w_irq_request)
    );

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_irq_request = r_irq_request;

    // a held input item is neither dropped nor altered while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item))
        else $error("input item lost while stalled");

    // interrupt request only on a tick result
    a_irq_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_irq_request |-> r_out_func == cit_pkg::FUNC_TICK)
        else $error("irq on non-tick result");

    // read data only on a read result
    a_rd_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_data != 8'd0) |-> r_out_func == cit_pkg::FUNC_READ)
        else $error("read data on non-read result");

endmodule

>>> hw/rtl/cit_core.sv
module cit_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  cit_pkg::t_item i_item,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic           i_cfg_data,
    output logic [7:0]     o_read_data,
    output logic           o_irq_request
);

    logic [7:0]  r_reg_bytes [16];
    logic [7:0]  n_reg_bytes [16];
    logic [15:0] r_count_a, n_count_a, r_reload_a, n_reload_a;
    logic [15:0] r_count_b, n_count_b, r_reload_b, n_reload_b;
    logic        r_enabled_a, n_enabled_a, r_enabled_b, n_enabled_b;
    logic        r_single_shot_a, n_single_shot_a, r_single_shot_b, n_single_shot_b;
    logic        r_counts_cycles_a, n_counts_cycles_a;
    logic [1:0]  r_source_mode_b, n_source_mode_b;
    logic [1:0]  r_uf_flags, n_uf_flags;
    logic        r_alarm, n_alarm;
    logic        r_unit_is_second, r_irq_enable;

    logic w_tick;
    logic w_uf_a;
    logic w_chain;
    logic w_uf_b;

    // a tick underflows a timer when 0 < count <= cycles
    assign w_tick  = i_fire && (i_item.func == cit_pkg::FUNC_TICK) && !r_unit_is_second;
    assign w_uf_a  = w_tick && r_counts_cycles_a && (r_count_a != 16'd0)
                     && (r_count_a <= i_item.tick_cycles);
    assign w_chain = w_uf_a && (r_source_mode_b == cit_pkg::SRC_CHAIN);
    assign w_uf_b  = (w_chain && (r_count_b == 16'd1))
                     || (w_tick && (r_source_mode_b == cit_pkg::SRC_CYCLES)
                         && (r_count_b != 16'd0) && (r_count_b <= i_item.tick_cycles));

    always_comb begin
        n_reg_bytes       = r_reg_bytes;
        n_count_a         = r_count_a;
        n_reload_a        = r_reload_a;
        n_count_b         = r_count_b;
        n_reload_b        = r_reload_b;
        n_enabled_a       = r_enabled_a;
        n_enabled_b       = r_enabled_b;
        n_single_shot_a   = r_single_shot_a;
        n_single_shot_b   = r_single_shot_b;
        n_counts_cycles_a = r_counts_cycles_a;
        n_source_mode_b   = r_source_mode_b;
        n_uf_flags        = r_uf_flags;
        n_alarm           = r_alarm;
        o_read_data       = 8'd0;
        o_irq_request     = 1'b0;

        if (i_fire) begin
            unique case (i_item.func)
                cit_pkg::FUNC_READ: begin
                    case (i_item.reg_addr)
                        cit_pkg::REG_TA_LO: o_read_data = r_count_a[7:0];
                        cit_pkg::REG_TA_HI: o_read_data = r_count_a[15:8];
                        cit_pkg::REG_TB_LO: o_read_data = r_count_b[7:0];
                        cit_pkg::REG_TB_HI: o_read_data = r_count_b[15:8];
                        cit_pkg::REG_ICR: begin
                            // read clears the flags
                            o_read_data = {5'd0, r_alarm, r_uf_flags};
                            n_uf_flags  = 2'd0;
                            n_alarm     = 1'b0;
                        end
                        default: o_read_data = r_reg_bytes[i_item.reg_addr];
                    endcase
                end
                cit_pkg::FUNC_WRITE: begin
                    case (i_item.reg_addr)
                        cit_pkg::REG_TA_LO: n_reload_a[7:0]  = i_item.write_data;
                        cit_pkg::REG_TA_HI: n_reload_a[15:8] = i_item.write_data;
                        cit_pkg::REG_TB_LO: n_reload_b[7:0]  = i_item.write_data;
                        cit_pkg::REG_TB_HI: n_reload_b[15:8] = i_item.write_data;
                        cit_pkg::REG_ICR: begin
                            if (i_item.write_data[0]) n_enabled_a = i_item.write_data[7];
                            if (i_item.write_data[1]) n_enabled_b = i_item.write_data[7];
                        end
                        cit_pkg::REG_CRA: begin
                            n_enabled_a       = i_item.write_data[0];
                            n_single_shot_a   = i_item.write_data[3];
                            if (i_item.write_data[4]) n_count_a = r_reload_a;
                            n_counts_cycles_a = !i_item.write_data[5];
                        end
                        cit_pkg::REG_CRB: begin
                            n_enabled_b     = i_item.write_data[0];
                            n_single_shot_b = i_item.write_data[3];
                            if (i_item.write_data[4]) n_count_b = r_reload_b;
                            n_source_mode_b = i_item.write_data[6:5];
                            n_alarm         = i_item.write_data[7];
                        end
                        default: ;
                    endcase
                    n_reg_bytes[i_item.reg_addr] = i_item.write_data;
                end
                cit_pkg::FUNC_TICK: begin
                    if (w_tick && r_counts_cycles_a) begin
                        if (w_uf_a) begin
                            o_irq_request             = r_enabled_a && r_irq_enable;
                            n_uf_flags[0]             = 1'b1;
                            n_reg_bytes[cit_pkg::REG_ICR][0] = 1'b1;
                            n_count_a                 = r_reload_a;
                            if (r_single_shot_a) n_enabled_a = 1'b0;
                        end else begin
                            n_count_a = r_count_a - i_item.tick_cycles;
                        end
                    end
                    if (w_uf_b) begin
                        n_uf_flags[1]             = 1'b1;
                        n_reg_bytes[cit_pkg::REG_ICR][1] = 1'b1;
                        n_count_b                 = r_reload_b;
                        if (r_single_shot_b) n_enabled_b = 1'b0;
                    end else if (w_chain) begin
                        n_count_b = r_count_b - 16'd1;
                    end else if (w_tick && (r_source_mode_b == cit_pkg::SRC_CYCLES)) begin
                        n_count_b = r_count_b - i_item.tick_cycles;
                    end
                end
                cit_pkg::FUNC_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_reg_bytes[i] <= 8'd0;
            end
            r_count_a         <= 16'd0;
            r_reload_a        <= 16'd0;
            r_count_b         <= 16'd0;
            r_reload_b        <= 16'd0;
            r_enabled_a       <= 1'b0;
            r_enabled_b       <= 1'b0;
            r_single_shot_a   <= 1'b0;
            r_single_shot_b   <= 1'b0;
            r_counts_cycles_a <= 1'b0;
            r_source_mode_b   <= 2'd0;
            r_uf_flags        <= 2'd0;
            r_alarm           <= 1'b0;
            r_unit_is_second  <= 1'b0;
            r_irq_enable      <= 1'b1;
        end else begin
            r_reg_bytes       <= n_reg_bytes;
            r_count_a         <= n_count_a;
            r_reload_a        <= n_reload_a;
            r_count_b         <= n_count_b;
            r_reload_b        <= n_reload_b;
            r_enabled_a       <= n_enabled_a;
            r_enabled_b       <= n_enabled_b;
            r_single_shot_a   <= n_single_shot_a;
            r_single_shot_b   <= n_single_shot_b;
            r_counts_cycles_a <= n_counts_cycles_a;
            r_source_mode_b   <= n_source_mode_b;
            r_uf_flags        <= n_uf_flags;
            r_alarm           <= n_alarm;
            if (i_cfg_we) begin
                if (i_cfg_index == cit_pkg::CFG_UNIT_IS_SECOND) r_unit_is_second <= i_cfg_data;
                if (i_cfg_index == cit_pkg::CFG_IRQ_ENABLE)     r_irq_enable     <= i_cfg_data;
            end
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import cit_pkg::*;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } t_idle;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = FUNC_NONE;
    logic [3:0]  i_reg_addr = '0;
    logic [7:0]  i_write_data = '0;
    logic [15:0] i_tick_cycles = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_irq_request;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_UNIT_IS_SECOND;
    logic        i_cfg_data = 1'b0;

    complex_interface_timer_pair_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_tick_cycles (i_tick_cycles),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_irq_request (o_irq_request),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // transfer seen at the last rising edge
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic cfg_fire = 1'b0;

    t_item  bus_ops[$];
    t_reply reply_q[$];

    t_idle       tx_mode = IDLE_FULL;
    t_idle       rx_mode = IDLE_FULL;
    int unsigned tx_gap = 0;
    int unsigned rx_wait = 0;
    logic        rx_hold = 1'b0;
    logic        hold_go = 1'b0;

    int unsigned n_errors = 0;
    int unsigned n_ops = 0;
    int unsigned n_ticks = 0;
    int unsigned n_irqs = 0;
    int unsigned n_checked = 0;
    int unsigned n_cfg = 0;

    // timer pair state as predicted
    logic [7:0]  regfile [16];
    logic [15:0] cnt_a = '0;
    logic [15:0] latch_a = '0;
    logic [15:0] cnt_b = '0;
    logic [15:0] latch_b = '0;
    logic        en_a = 1'b0;
    logic        en_b = 1'b0;
    logic        oneshot_a = 1'b0;
    logic        oneshot_b = 1'b0;
    logic        a_counts_clk = 1'b0;
    logic [1:0]  b_src = SRC_CYCLES;
    logic [1:0]  uf_flags = '0;
    logic        alarm = 1'b0;
    logic        second_unit = 1'b0;
    logic        irq_gate = 1'b1;

    initial begin
        for (int i = 0; i < 16; i++)
            regfile[i] = '0;
    end

    task automatic timer_b_expire();
        uf_flags[1] = 1'b1;
        regfile[REG_ICR][1] = 1'b1;
        cnt_b = latch_b;
        if (oneshot_b)
            en_b = 1'b0;
    endtask

    task automatic timer_pair_step(input t_func f, input logic [3:0] addr,
                                   input logic [7:0] data, input logic [15:0] cyc,
                                   output logic [7:0] rd, output logic irq);
        rd = '0;
        irq = 1'b0;
        case (f)
            FUNC_READ: begin
                case (addr)
                    REG_TA_LO: rd = cnt_a[7:0];
                    REG_TA_HI: rd = cnt_a[15:8];
                    REG_TB_LO: rd = cnt_b[7:0];
                    REG_TB_HI: rd = cnt_b[15:8];
                    REG_ICR: begin
                        rd = {5'b0, alarm, uf_flags};
                        uf_flags = '0;
                        alarm = 1'b0;
                    end
                    default: rd = regfile[addr];
                endcase
            end
            FUNC_WRITE: begin
                case (addr)
                    REG_TA_LO: latch_a[7:0] = data;
                    REG_TA_HI: latch_a[15:8] = data;
                    REG_TB_LO: latch_b[7:0] = data;
                    REG_TB_HI: latch_b[15:8] = data;
                    REG_ICR: begin
                        if (data[0])
                            en_a = data[7];
                        if (data[1])
                            en_b = data[7];
                    end
                    REG_CRA: begin
                        en_a = data[0];
                        oneshot_a = data[3];
                        if (data[4])
                            cnt_a = latch_a;
                        a_counts_clk = !data[5];
                    end
                    REG_CRB: begin
                        en_b = data[0];
                        oneshot_b = data[3];
                        if (data[4])
                            cnt_b = latch_b;
                        b_src = data[6:5];
                        alarm = data[7];
                    end
                    default: ;
                endcase
                regfile[addr] = data;
            end
            FUNC_TICK: begin
                if (!second_unit) begin
                    if (a_counts_clk) begin
                        if (cnt_a != 0 && cnt_a <= cyc) begin
                            irq = en_a && irq_gate;
                            uf_flags[0] = 1'b1;
                            regfile[REG_ICR][0] = 1'b1;
                            // chained B steps once per A underflow
                            if (b_src == SRC_CHAIN) begin
                                if (cnt_b == 16'd1)
                                    timer_b_expire();
                                else
                                    cnt_b = cnt_b - 16'd1;
                            end
                            cnt_a = latch_a;
                            if (oneshot_a)
                                en_a = 1'b0;
                        end else begin
                            cnt_a = cnt_a - cyc;
                        end
                    end
                    if (b_src == SRC_CYCLES) begin
                        if (cnt_b != 0 && cnt_b <= cyc)
                            timer_b_expire();
                        else
                            cnt_b = cnt_b - cyc;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    function automatic int unsigned draw_wait(input t_idle mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 11);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        endcase
    endfunction

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_reply     want;
        logic [7:0] rd;
        logic       irq;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && o_in_ready;
            out_fire <= o_out_valid && i_out_ready;
            cfg_fire <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_UNIT_IS_SECOND)
                    second_unit = i_cfg_data;
                else
                    irq_gate = i_cfg_data;
                n_cfg++;
            end
            if (o_out_valid && i_out_ready) begin
                if (reply_q.size() == 0) begin
                    flag_mismatch("unexpected result, read_data", 8'h00, o_read_data);
                end else begin
                    want = reply_q.pop_front();
                    if (o_read_data !== want.read_data)
                        flag_mismatch("read_data", want.read_data, o_read_data);
                    if (o_irq_request !== want.irq_request)
                        flag_mismatch("irq_request", {7'b0, want.irq_request},
                                      {7'b0, o_irq_request});
                    n_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                timer_pair_step(t_func'(i_func), i_reg_addr, i_write_data, i_tick_cycles,
                                rd, irq);
                want.read_data = rd;
                want.irq_request = irq;
                reply_q.push_back(want);
                n_ops++;
                if (i_func == FUNC_TICK)
                    n_ticks++;
                if (irq)
                    n_irqs++;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_item op;
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (tx_gap != 0) begin
                    i_in_valid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (bus_ops.size() != 0) begin
                    op = bus_ops.pop_front();
                    i_func <= op.func;
                    i_reg_addr <= op.reg_addr;
                    i_write_data <= op.write_data;
                    i_tick_cycles <= op.tick_cycles;
                    i_in_valid <= 1'b1;
                    tx_gap <= draw_wait(tx_mode);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        int unsigned w;
        if (i_rst_n) begin
            w = out_fire ? draw_wait(rx_mode) : rx_wait;
            if (rx_hold) begin
                i_out_ready <= 1'b0;
                rx_wait = w;
            end else if (w != 0) begin
                i_out_ready <= 1'b0;
                rx_wait = w - 1;
            end else begin
                i_out_ready <= 1'b1;
                rx_wait = 0;
            end
        end
    end

    // long receiver stall so the pipeline backs up into the input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #400000;
        $display("** complex_interface_timer_pair_unit: FAILED **");
        $finish;
    end

    task automatic push_op(input t_func f, input logic [3:0] addr, input logic [7:0] data,
                           input logic [15:0] cyc);
        t_item op;
        op.func = f;
        op.reg_addr = addr;
        op.write_data = data;
        op.tick_cycles = cyc;
        bus_ops.push_back(op);
    endtask

    function automatic logic [3:0] timer_reg();
        case ($urandom_range(0, 6))
            0: return REG_TA_LO;
            1: return REG_TA_HI;
            2: return REG_TB_LO;
            3: return REG_TB_HI;
            4: return REG_ICR;
            5: return REG_CRA;
            default: return REG_CRB;
        endcase
    endfunction

    task automatic push_random_op();
        int unsigned pick;
        logic [3:0]  addr;
        logic [7:0]  data;
        logic [15:0] cyc;
        pick = $urandom_range(0, 99);
        addr = 4'($urandom_range(0, 15));
        data = 8'($urandom_range(0, 255));
        cyc = 16'($urandom_range(0, 65535));
        if (pick < 5) begin
            push_op(FUNC_NONE, addr, data, cyc);
        end else if (pick < 40) begin
            case ($urandom_range(0, 4))
                0, 1: cyc = 16'($urandom_range(0, 8));
                2: cyc = 16'($urandom_range(0, 300));
                default: ;
            endcase
            push_op(FUNC_TICK, addr, data, cyc);
        end else if (pick < 68) begin
            if ($urandom_range(0, 1))
                addr = timer_reg();
            push_op(FUNC_READ, addr, data, cyc);
        end else begin
            if ($urandom_range(0, 3) != 0)
                addr = timer_reg();
            // keep latches short so underflows stay frequent
            case (addr)
                REG_TA_LO, REG_TB_LO: if ($urandom_range(0, 1)) data = 8'($urandom_range(0, 12));
                REG_TA_HI, REG_TB_HI: if ($urandom_range(0, 4) < 3) data = 8'h00;
                REG_CRA: if ($urandom_range(0, 9) < 7) data[5] = 1'b0;
                default: ;
            endcase
            push_op(FUNC_WRITE, addr, data, cyc);
        end
    endtask

    task automatic run_phase(input int unsigned n, input t_idle tx, input t_idle rx);
        logic [7:0] cr;
        tx_mode = tx;
        rx_mode = rx;
        push_op(FUNC_WRITE, REG_TA_LO, 8'($urandom_range(1, 12)), 16'h0);
        push_op(FUNC_WRITE, REG_TA_HI, 8'h00, 16'h0);
        push_op(FUNC_WRITE, REG_TB_LO, 8'($urandom_range(1, 12)), 16'h0);
        push_op(FUNC_WRITE, REG_TB_HI, 8'h00, 16'h0);
        cr = 8'($urandom_range(0, 255));
        push_op(FUNC_WRITE, REG_CRA, (cr & 8'h09) | 8'h10, 16'h0);
        cr = 8'($urandom_range(0, 255));
        push_op(FUNC_WRITE, REG_CRB, cr | 8'h10, 16'h0);
        repeat (n)
            push_random_op();
    endtask

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (bus_ops.size() != 0 || i_in_valid || reply_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do
            @(negedge i_clk);
        while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reload, one-shot, chaining, signal counting, flags, odd func code
        push_op(FUNC_READ, REG_ICR, 8'h00, 16'h0);
        push_op(FUNC_WRITE, REG_TA_LO, 8'h03, 16'h0);
        push_op(FUNC_WRITE, REG_TA_HI, 8'h00, 16'h0);
        push_op(FUNC_WRITE, REG_CRA, 8'h11, 16'h0);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'h0000);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'h0003);
        push_op(FUNC_READ, REG_ICR, 8'h00, 16'h0);
        push_op(FUNC_WRITE, REG_TB_LO, 8'h02, 16'h0);
        push_op(FUNC_WRITE, REG_CRB, 8'h51, 16'h0);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'hFFFF);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'h0003);
        push_op(FUNC_READ, REG_TB_LO, 8'h00, 16'h0);
        push_op(FUNC_READ, REG_ICR, 8'h00, 16'h0);
        push_op(FUNC_WRITE, REG_CRA, 8'h29, 16'h0);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'h0005);
        push_op(FUNC_WRITE, REG_CRA, 8'h19, 16'h0);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'h0003);
        push_op(FUNC_TICK, 4'd0, 8'h00, 16'h0003);
        push_op(FUNC_WRITE, REG_ICR, 8'h81, 16'h0);
        push_op(FUNC_WRITE, REG_ICR, 8'h03, 16'h0);
        push_op(FUNC_WRITE, REG_CRB, 8'hA0, 16'h0);
        push_op(FUNC_READ, REG_ICR, 8'h00, 16'h0);
        push_op(FUNC_NONE, 4'hF, 8'hFF, 16'hFFFF);
        push_op(FUNC_WRITE, 4'd0, 8'hFF, 16'h0);
        push_op(FUNC_READ, 4'd0, 8'h00, 16'h0);
        wait_idle();

        write_cfg(CFG_UNIT_IS_SECOND, 1'b0);
        write_cfg(CFG_IRQ_ENABLE, 1'b1);
        run_phase(100, IDLE_NONE, IDLE_NONE);
        wait_idle();

        write_cfg(CFG_IRQ_ENABLE, 1'b0);
        run_phase(100, IDLE_NONE, IDLE_FULL);
        hold_go = 1'b1;
        wait_idle();

        write_cfg(CFG_UNIT_IS_SECOND, 1'b1);
        run_phase(100, IDLE_SPARSE, IDLE_FULL);
        wait_idle();

        write_cfg(CFG_IRQ_ENABLE, 1'b1);
        run_phase(60, IDLE_FULL, IDLE_SPARSE);
        wait_idle();

        write_cfg(CFG_UNIT_IS_SECOND, 1'b0);
        run_phase(140, IDLE_SPARSE, IDLE_SPARSE);
        wait_idle();
        repeat (10) @(negedge i_clk);

        $display("covered %0d bus transfers (%0d ticks, %0d timer A interrupts), %0d config writes",
                 n_ops, n_ticks, n_irqs, n_cfg);
        $display("checked %0d results, %0d mismatches, %0d results outstanding",
                 n_checked, n_errors, reply_q.size());
        if (n_errors == 0 && reply_q.size() == 0)
            $display("** complex_interface_timer_pair_unit: PASSED **");
        else
            $display("** complex_interface_timer_pair_unit: FAILED **");
        $finish;
    end

endmodule
